// ===== src/rsi_wilder_indicator_top_macros.svh =====
`ifndef RSI_WILDER_INDICATOR_TOP_MACROS_SVH
`define RSI_WILDER_INDICATOR_TOP_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define RSIW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define RSIW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rsiw_pkg.sv =====
package rsiw_pkg;

    localparam int PERIOD_W       = 8;
    localparam int PADDR_W        = 3;
    localparam int RSI_W          = 15;
    localparam int RSI_STEPS      = RSI_W;
    localparam int RSI_CNT_W      = 4;
    localparam int RSI_TOT_LIMIT  = 48;
    localparam int DIV_DIGIT_BITS = 4;

    // 25600 = 2^14 + 2^13 + 2^10
    localparam int RSI_SH_A = 14;
    localparam int RSI_SH_B = 13;
    localparam int RSI_SH_C = 10;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 8'd14;
    localparam logic [PERIOD_W-1:0]  SMOOTH_MARK  = 8'hFF;
    localparam logic [RSI_W-1:0]     RSI_FULL     = 15'd25600;
    localparam logic [RSI_W-1:0]     RSI_NEUTRAL  = 15'd12800;
    localparam logic [PADDR_W-3:0]   REG_IDX_PERIOD = '0;

    typedef struct packed {
        logic [31:0] price;
        logic        series_start;
    } sample_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi_value;
        logic             warming_up;
    } result_t;

    typedef struct packed {
        logic take;
        logic diff;
        logic accum;
        logic mul;
        logic div_start;
        logic div_write;
        logic set_mark;
        logic rshift;
        logic rtot;
        logic rnum;
        logic rstep;
        logic load_out;
        logic neutral;
        logic sel_loss;
        logic warm_path;
    } cmd_t;

    typedef struct packed {
        logic have;
        logic smoothing;
        logic warm_done;
        logic div_done;
    } status_t;

endpackage

// ===== src/rsi_wilder_indicator_top.sv =====
// channel   dir  handshake                 word
// cfg       in   psel/penable/pwrite       smoothing_period at byte address 0
// sample    in   sample_valid/sample_stall price, series_start
// result    out  result_valid/result_stall rsi_value, warming_up
//
// A first price and a warm-up price go straight to the output. The price that ends
// warm-up and every smoothing price also pass through the shared divider, which
// retires four quotient bits per cycle, and through the 15-step RSI division.
// Reset clears the series state and loads a smoothing period of 14.
// A stalled result holds in the output register; the next word is accepted meanwhile
// and its result waits until the register is free.
module rsi_wilder_indicator_top
    import rsiw_pkg::*;
#(
    parameter int PRICE_BITS    = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  sample_t            sample_word,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result_word
);

    logic [PERIOD_W-1:0] period_reg;
    logic                period_hit;
    cmd_t                cmd;
    status_t             status;

    assign period_hit = (paddr[PADDR_W-1:2] == REG_IDX_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (psel && penable && pwrite && period_hit)
        begin
            period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = period_hit ? 32'(period_reg) : '0;

    rsiw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    rsiw_dp #(
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .period      (period_reg),
        .sample_word (sample_word),
        .cmd         (cmd),
        .status      (status),
        .result_word (result_word)
    );

endmodule

// ===== src/rsiw_div.sv =====
module rsiw_div
    import rsiw_pkg::*;
#(
    parameter int DVW = 56
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVW-1:0]      dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                done,
    output logic [DVW-1:0]      quotient
);

    localparam int DVP   = ((DVW + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS) * DIV_DIGIT_BITS;
    localparam int STEPS = DVP / DIV_DIGIT_BITS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                active_reg, active_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DVP-1:0]      dvd_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] divisor_reg;
    logic [DVP-1:0]      dvd_step;
    logic [PERIOD_W-1:0] rem_step;

    // four restoring steps per cycle; quotient bits shift in behind the dividend
    always_comb
    begin
        logic [PERIOD_W-1:0] r;
        logic [DVP-1:0]      d;
        logic [PERIOD_W:0]   t;
        r = rem_reg;
        d = dvd_reg;
        for (int k = 0; k < DIV_DIGIT_BITS; k++)
        begin
            t = {r, d[DVP-1]};
            d = {d[DVP-2:0], 1'b0};
            if (t >= {1'b0, divisor_reg})
            begin
                r = PERIOD_W'(t - {1'b0, divisor_reg});
                d[0] = 1'b1;
            end
            else
            begin
                r = t[PERIOD_W-1:0];
            end
        end
        rem_step = r;
        dvd_step = d;
    end

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg     <= DVP'(dividend);
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (active_reg)
        begin
            dvd_reg <= dvd_step;
            rem_reg <= rem_step;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[DVW-1:0];

endmodule

// ===== src/rsiw_dp.sv =====
module rsiw_dp
    import rsiw_pkg::*;
#(
    parameter int PRICE_BITS    = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PERIOD_W-1:0] period,
    input  sample_t             sample_word,
    input  cmd_t                cmd,
    output status_t             status,
    output result_t             result_word
);

    localparam int AW   = PRICE_BITS + FRACTION_BITS;
    localparam int DVW  = AW + PERIOD_W;
    localparam int TOTW = AW + 1;
    localparam int NUMW = TOTW + RSI_W;

    // series state
    logic [PRICE_BITS-1:0] prev_reg;
    logic                  have_reg;
    logic [PERIOD_W-1:0]   count_reg;
    logic [AW-1:0]         gain_avg_reg;
    logic [AW-1:0]         loss_avg_reg;

    // per-word working registers
    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] gain_chg_reg;
    logic [PRICE_BITS-1:0] loss_chg_reg;
    logic [DVW-1:0]        mul_reg;
    logic [AW-1:0]         gs_reg;
    logic [AW-1:0]         ls_reg;
    logic [TOTW-1:0]       tot_reg;
    logic [NUMW-1:0]       numa_reg;
    logic [NUMW-1:0]       rem_reg;
    logic [NUMW-1:0]       dsr_reg;
    logic [RSI_W-1:0]      quo_reg;
    logic                  zero_loss_reg;
    result_t               result_reg;

    logic [PERIOD_W-1:0]   p_eff;
    logic [PERIOD_W-1:0]   pm1;
    logic [AW-1:0]         avg_sel;
    logic [PRICE_BITS-1:0] chg_sel;
    logic [DVW-1:0]        mul_full;
    logic [DVW-1:0]        div_dividend;
    logic [PERIOD_W-1:0]   div_divisor;
    logic                  div_done;
    logic [DVW-1:0]        div_quotient;
    logic [TOTW-1:0]       tot_wide;
    logic                  tot_shift;

    assign p_eff   = (period == '0) ? PERIOD_W'(1) : period;
    assign pm1     = p_eff - PERIOD_W'(1);
    assign avg_sel = cmd.sel_loss ? loss_avg_reg : gain_avg_reg;
    assign chg_sel = cmd.sel_loss ? loss_chg_reg : gain_chg_reg;
    assign mul_full = DVW'(avg_sel) * DVW'(pm1);

    // warm-up: sum * 2^F / count; smoothing: (avg*(p-1) + x*2^F) / p
    assign div_dividend = cmd.warm_path ? (DVW'(avg_sel) << FRACTION_BITS)
                                        : (mul_reg + (DVW'(chg_sel) << FRACTION_BITS));
    assign div_divisor  = cmd.warm_path ? count_reg : p_eff;

    // halve both averages once if their sum runs past 48 bits
    assign tot_wide  = TOTW'(gain_avg_reg) + TOTW'(loss_avg_reg);
    assign tot_shift = (tot_wide >> RSI_TOT_LIMIT) != '0;

    rsiw_div #(
        .DVW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign status.have      = have_reg;
    assign status.smoothing = (count_reg == SMOOTH_MARK);
    assign status.warm_done = ({1'b0, count_reg} + 9'd1) >= {1'b0, p_eff};
    assign status.div_done  = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            have_reg     <= 1'b0;
            count_reg    <= '0;
            gain_avg_reg <= '0;
            loss_avg_reg <= '0;
        end
        else
        begin
            if (cmd.take && sample_word.series_start)
            begin
                prev_reg     <= '0;
                have_reg     <= 1'b0;
                count_reg    <= '0;
                gain_avg_reg <= '0;
                loss_avg_reg <= '0;
            end
            if (cmd.diff)
            begin
                prev_reg <= price_reg;
                have_reg <= 1'b1;
            end
            if (cmd.accum)
            begin
                gain_avg_reg <= gain_avg_reg + AW'(gain_chg_reg);
                loss_avg_reg <= loss_avg_reg + AW'(loss_chg_reg);
                count_reg    <= count_reg + PERIOD_W'(1);
            end
            if (cmd.div_write)
            begin
                if (cmd.sel_loss)
                begin
                    loss_avg_reg <= div_quotient[AW-1:0];
                end
                else
                begin
                    gain_avg_reg <= div_quotient[AW-1:0];
                end
            end
            if (cmd.set_mark)
            begin
                count_reg <= SMOOTH_MARK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            price_reg <= PRICE_BITS'(sample_word.price);
        end
        if (cmd.diff)
        begin
            if (price_reg > prev_reg)
            begin
                gain_chg_reg <= price_reg - prev_reg;
                loss_chg_reg <= '0;
            end
            else
            begin
                gain_chg_reg <= '0;
                loss_chg_reg <= prev_reg - price_reg;
            end
        end
        if (cmd.mul)
        begin
            mul_reg <= mul_full;
        end
        if (cmd.rshift)
        begin
            gs_reg <= tot_shift ? (gain_avg_reg >> 1) : gain_avg_reg;
            ls_reg <= tot_shift ? (loss_avg_reg >> 1) : loss_avg_reg;
        end
        if (cmd.rtot)
        begin
            tot_reg       <= TOTW'(gs_reg) + TOTW'(ls_reg);
            numa_reg      <= (NUMW'(gs_reg) << RSI_SH_A) + (NUMW'(gs_reg) << RSI_SH_B);
            zero_loss_reg <= (ls_reg == '0);
        end
        if (cmd.rnum)
        begin
            // gain * 25600 + total / 2, rounds half up
            rem_reg <= numa_reg + (NUMW'(gs_reg) << RSI_SH_C) + NUMW'(tot_reg >> 1);
            dsr_reg <= NUMW'(tot_reg) << (RSI_STEPS - 1);
            quo_reg <= '0;
        end
        if (cmd.rstep)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_reg <= rem_reg - dsr_reg;
                quo_reg <= {quo_reg[RSI_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[RSI_W-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
        if (cmd.load_out)
        begin
            if (cmd.neutral)
            begin
                result_reg.rsi_value <= RSI_NEUTRAL;
            end
            else
            begin
                result_reg.rsi_value <= zero_loss_reg ? RSI_FULL : quo_reg;
            end
            result_reg.warming_up <= cmd.neutral;
        end
    end

    assign result_word = result_reg;

endmodule

// ===== src/rsiw_ctrl.sv =====
`include "rsi_wilder_indicator_top_macros.svh"

module rsiw_ctrl
    import rsiw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    output logic    result_valid,
    input  logic    result_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DIFF   = 11'b000_0000_0010,
        S_ACCUM  = 11'b000_0000_0100,
        S_MUL    = 11'b000_0000_1000,
        S_DLOAD  = 11'b000_0001_0000,
        S_DWAIT  = 11'b000_0010_0000,
        S_RSHIFT = 11'b000_0100_0000,
        S_RTOT   = 11'b000_1000_0000,
        S_RNUM   = 11'b001_0000_0000,
        S_RDIV   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic                 sel_loss_reg, sel_loss_next;
    logic                 warm_path_reg, warm_path_next;
    logic                 neutral_reg, neutral_next;
    logic [RSI_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic                 result_valid_reg, result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        sel_loss_next     = sel_loss_reg;
        warm_path_next    = warm_path_reg;
        neutral_next      = neutral_reg;
        rcnt_next         = rcnt_reg;
        result_valid_next = result_valid_reg;
        cmd               = '0;
        cmd.sel_loss      = sel_loss_reg;
        cmd.warm_path     = warm_path_reg;
        cmd.neutral       = neutral_reg;

        // drop the word once taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.take     = 1'b1;
                    neutral_next = 1'b0;
                    state_next   = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff = 1'b1;
                if (!status.have)
                begin
                    neutral_next = 1'b1;
                    state_next   = S_OUT;
                end
                else if (status.smoothing)
                begin
                    warm_path_next = 1'b0;
                    sel_loss_next  = 1'b0;
                    state_next     = S_MUL;
                end
                else
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (status.warm_done)
                begin
                    warm_path_next = 1'b1;
                    sel_loss_next  = 1'b0;
                    state_next     = S_DLOAD;
                end
                else
                begin
                    neutral_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_write = 1'b1;
                    if (!sel_loss_reg)
                    begin
                        sel_loss_next = 1'b1;
                        state_next    = warm_path_reg ? S_DLOAD : S_MUL;
                    end
                    else
                    begin
                        cmd.set_mark = warm_path_reg;
                        state_next   = S_RSHIFT;
                    end
                end
            end
            S_RSHIFT:
            begin
                cmd.rshift = 1'b1;
                state_next = S_RTOT;
            end
            S_RTOT:
            begin
                cmd.rtot   = 1'b1;
                state_next = S_RNUM;
            end
            S_RNUM:
            begin
                cmd.rnum   = 1'b1;
                rcnt_next  = '0;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                cmd.rstep = 1'b1;
                if (rcnt_reg == RSI_CNT_W'(RSI_STEPS - 1))
                begin
                    rcnt_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load_out      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sel_loss_reg     <= 1'b0;
            warm_path_reg    <= 1'b0;
            neutral_reg      <= 1'b0;
            rcnt_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sel_loss_reg     <= sel_loss_next;
            warm_path_reg    <= warm_path_next;
            neutral_reg      <= neutral_next;
            rcnt_reg         <= rcnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

    `RSIW_ASSERT_NOW(a_done_in_wait, clk, rst_n, status.div_done, state_reg == S_DWAIT, "divider done outside wait state")
    `RSIW_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_out, result_valid_reg, "loaded result not presented")
    `RSIW_ASSERT_NOW(a_mark_after_loss, clk, rst_n, cmd.set_mark, sel_loss_reg && warm_path_reg, "smoothing mark set before both averages")
    `RSIW_ASSERT_NOW(a_rcnt_range, clk, rst_n, 1'b1, rcnt_reg < RSI_CNT_W'(RSI_STEPS), "rsi step count out of range")

endmodule
